FILE: sv/ccim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccim_pkg
// Shared widths, register indexes, geometry state codes and bundled types.
// ----------------------------------------------------------------------------
package ccim_pkg;

  localparam int DW      = 32;
  localparam int CFG_IW  = 2;
  localparam int CNT_W   = $clog2(DW + 1);

  localparam logic [CFG_IW-1:0] REG_TOTAL_COUNT  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_WORKER_COUNT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_POLICY_MODE  = 2'd2;

  localparam logic MODE_CHUNKED = 1'b0;
  localparam logic MODE_CYCLIC  = 1'b1;

  typedef enum logic [2:0] {
    G_START,
    G_DIV1,
    G_LEN,
    G_DIV2,
    G_MUL,
    G_DIV3,
    G_DONE
  } geom_state_t;

  // distribution geometry, fixed between configuration writes
  typedef struct packed {
    logic          ready;
    logic [DW-1:0] len;
    logic [DW-1:0] num;
    logic [DW-1:0] last;
    logic [DW:0]   first;   // last * num, may pass 2^32
    logic [DW-1:0] fm;      // first mod (num - 1)
  } geom_t;

  // item sideband carried alongside the divider
  typedef struct packed {
    logic [DW-1:0] idx;
    logic          oor;
    logic          cyc;
    logic          hi;
  } side_t;

endpackage

FILE: sv/ccim_seq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccim_seq_div
// Radix-2 restoring divider, one quotient bit per cycle, for geometry setup.
// ----------------------------------------------------------------------------
module ccim_seq_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ccim_pkg::DW-1:0]   dividend,
  input  logic [ccim_pkg::DW-1:0]   divisor,
  output logic                      done,
  output logic [ccim_pkg::DW-1:0]   quotient,
  output logic [ccim_pkg::DW-1:0]   remainder
);

  logic                        busy;
  logic [ccim_pkg::CNT_W-1:0]  cnt;
  logic [ccim_pkg::DW-1:0]     rem;
  logic [ccim_pkg::DW-1:0]     quo;
  logic [ccim_pkg::DW-1:0]     dvs;
  logic [ccim_pkg::DW:0]       trial;
  logic                        ge;

  assign trial = {rem, quo[ccim_pkg::DW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ccim_pkg::CNT_W'(ccim_pkg::DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ccim_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? ccim_pkg::DW'(trial - {1'b0, dvs}) : trial[ccim_pkg::DW-1:0];
      quo <= {quo[ccim_pkg::DW-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: sv/ccim_geometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccim_geometry
// Works out chunk length, chunk count, last chunk length and helper terms
// after reset and after every register write, using one serial divider.
// ----------------------------------------------------------------------------
module ccim_geometry #(
  parameter int MAX_CHUNK = 16384
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [ccim_pkg::DW-1:0]   total,    // already masked to index width
  input  logic [10:0]               workers,
  output ccim_pkg::geom_t           geom
);

  ccim_pkg::geom_state_t state, state_next;

  logic                     div_start;
  logic [ccim_pkg::DW-1:0]  div_a;
  logic [ccim_pkg::DW-1:0]  div_b;
  logic                     div_done;
  logic [ccim_pkg::DW-1:0]  div_q;
  logic [ccim_pkg::DW-1:0]  div_r;
  logic [ccim_pkg::DW-1:0]  workers_eff;
  logic [ccim_pkg::DW-1:0]  len;
  logic [ccim_pkg::DW-1:0]  num;
  logic [ccim_pkg::DW-1:0]  last;
  logic [ccim_pkg::DW:0]    first;
  logic [ccim_pkg::DW-1:0]  fm;
  logic [2*ccim_pkg::DW-1:0] prod;

  assign workers_eff = (workers == 11'd0) ? ccim_pkg::DW'(1) : ccim_pkg::DW'(workers);
  assign prod        = last * num;

  ccim_seq_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccim_pkg::G_START;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_a      = total;
    div_b      = workers_eff;
    case (state)
      ccim_pkg::G_START: begin
        if (total != '0) begin
          div_start  = 1'b1;
          state_next = ccim_pkg::G_DIV1;
        end else begin
          state_next = ccim_pkg::G_DONE;
        end
      end
      ccim_pkg::G_DIV1: begin
        if (div_done) state_next = ccim_pkg::G_LEN;
      end
      ccim_pkg::G_LEN: begin
        div_start  = 1'b1;
        div_b      = len;
        state_next = ccim_pkg::G_DIV2;
      end
      ccim_pkg::G_DIV2: begin
        if (div_done) state_next = ccim_pkg::G_MUL;
      end
      ccim_pkg::G_MUL: begin
        // first mod (num - 1) equals last mod (num - 1)
        if (num > ccim_pkg::DW'(1)) begin
          div_start  = 1'b1;
          div_a      = last;
          div_b      = num - 1'b1;
          state_next = ccim_pkg::G_DIV3;
        end else begin
          state_next = ccim_pkg::G_DONE;
        end
      end
      ccim_pkg::G_DIV3: begin
        if (div_done) state_next = ccim_pkg::G_DONE;
      end
      ccim_pkg::G_DONE: state_next = ccim_pkg::G_DONE;
      default:          state_next = ccim_pkg::G_START;
    endcase
    if (restart) begin
      state_next = ccim_pkg::G_START;
      div_start  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ccim_pkg::G_START: begin
        len   <= ccim_pkg::DW'(1);
        num   <= ccim_pkg::DW'(1);
        last  <= ccim_pkg::DW'(1);
        first <= (ccim_pkg::DW+1)'(1);
        fm    <= '0;
      end
      ccim_pkg::G_DIV1: begin
        if (div_done) begin
          if (div_q > ccim_pkg::DW'(MAX_CHUNK)) len <= ccim_pkg::DW'(MAX_CHUNK);
          else len <= div_q + ccim_pkg::DW'(div_r != '0);
        end
      end
      ccim_pkg::G_DIV2: begin
        if (div_done) begin
          num  <= div_q + ccim_pkg::DW'(div_r != '0);
          last <= (div_r == '0) ? len : div_r;
        end
      end
      ccim_pkg::G_MUL: begin
        first <= prod[ccim_pkg::DW:0];
        fm    <= '0;
      end
      ccim_pkg::G_DIV3: begin
        if (div_done) fm <= div_r;
      end
      default: begin
        len <= len;
      end
    endcase
  end

  assign geom.ready = (state == ccim_pkg::G_DONE) && !restart;
  assign geom.len   = len;
  assign geom.num   = num;
  assign geom.last  = last;
  assign geom.first = first;
  assign geom.fm    = fm;

endmodule

FILE: sv/ccim_pipe_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccim_pipe_div
// Fully pipelined restoring divider, one quotient bit per stage, with
// per-stage valid and a common advance enable. Sideband travels alongside.
// ----------------------------------------------------------------------------
module ccim_pipe_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [ccim_pkg::DW-1:0]   in_dividend,
  input  logic [ccim_pkg::DW-1:0]   in_divisor,
  input  ccim_pkg::side_t           in_side,
  output logic                      out_valid,
  output logic [ccim_pkg::DW-1:0]   out_quotient,
  output logic [ccim_pkg::DW-1:0]   out_remainder,
  output ccim_pkg::side_t           out_side
);

  localparam int N = ccim_pkg::DW;

  logic                     v   [0:N];
  logic [ccim_pkg::DW-1:0]  rem [0:N];
  logic [ccim_pkg::DW-1:0]  quo [0:N];
  logic [ccim_pkg::DW-1:0]  dvs [0:N];
  ccim_pkg::side_t          sd  [0:N];

  assign v[0]   = in_valid;
  assign rem[0] = '0;
  assign quo[0] = in_dividend;
  assign dvs[0] = in_divisor;
  assign sd[0]  = in_side;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [ccim_pkg::DW:0] trial;
    logic                  ge;

    assign trial = {rem[k], quo[k][ccim_pkg::DW-1]};
    assign ge    = trial >= {1'b0, dvs[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? ccim_pkg::DW'(trial - {1'b0, dvs[k]})
                       : trial[ccim_pkg::DW-1:0];
        quo[k+1] <= {quo[k][ccim_pkg::DW-2:0], ge};
        dvs[k+1] <= dvs[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_valid     = v[N];
  assign out_quotient  = quo[N];
  assign out_remainder = rem[N];
  assign out_side      = sd[N];

endmodule

FILE: sv/cyclic_chunk_index_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_chunk_index_mapper_core
// Maps source indices to destination slot and chunk, chunked or cyclic.
// ----------------------------------------------------------------------------
// One index is taken every cycle while s_axis_tready is high, and its result
// passes through the input register, a 32-stage pipelined divider, a
// chunk/offset stage, a multiply stage and the output register; a stall on
// the output holds the whole pipeline. After reset and after every register
// write the geometry is recomputed by a serial divider, one bit per cycle;
// during the recompute s_axis_tready is low.
module cyclic_chunk_index_mapper_core #(
  parameter int MAX_CHUNK  = 16384,
  parameter int INDEX_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ccim_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,   // [31:0] source_index
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] dest_slot, [63:32] dest_chunk, [95:64] chunk_total
  output logic [95:0]                     m_axis_tdata,
  output logic                            m_axis_tuser    // [0] out_of_range
);

  localparam logic [ccim_pkg::DW-1:0] IDX_MASK =
    ccim_pkg::DW'((64'd1 << INDEX_BITS) - 64'd1);

  logic [31:0]  total_count;
  logic [10:0]  worker_count;
  logic         policy_mode;
  logic         restart;
  ccim_pkg::geom_t geom;

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && (cfg_index == ccim_pkg::REG_TOTAL_COUNT ||
                                   cfg_index == ccim_pkg::REG_WORKER_COUNT ||
                                   cfg_index == ccim_pkg::REG_POLICY_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_count  <= 32'd1;
      worker_count <= 11'd1;
      policy_mode  <= ccim_pkg::MODE_CHUNKED;
    end else if (cfg_valid) begin
      case (cfg_index)
        ccim_pkg::REG_TOTAL_COUNT:  total_count  <= cfg_data;
        ccim_pkg::REG_WORKER_COUNT: worker_count <= cfg_data[10:0];
        ccim_pkg::REG_POLICY_MODE:  policy_mode  <= cfg_data[0];
        default:                    total_count  <= total_count;
      endcase
    end
  end

  logic [ccim_pkg::DW-1:0] n_items;
  assign n_items = total_count & IDX_MASK;

  ccim_geometry #(.MAX_CHUNK(MAX_CHUNK)) u_geom (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .total   (n_items),
    .workers (worker_count),
    .geom    (geom)
  );

  // advance the whole pipeline whenever the output register is free
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && geom.ready;

  // input stage
  logic                    v0;
  logic [ccim_pkg::DW-1:0] idx0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_axis_tvalid && s_axis_tready;
  end

  always_ff @(posedge clk) begin
    if (en) idx0 <= s_axis_tdata & IDX_MASK;
  end

  // pick dividend and divisor for the item
  ccim_pkg::side_t         side0;
  logic [ccim_pkg::DW-1:0] dvd0;
  logic [ccim_pkg::DW-1:0] dvs0;

  always_comb begin
    side0.idx = idx0;
    side0.oor = idx0 >= n_items;
    side0.cyc = policy_mode == ccim_pkg::MODE_CYCLIC;
    side0.hi  = {1'b0, idx0} >= geom.first;
    if (!side0.cyc) begin
      dvd0 = idx0;
      dvs0 = geom.len;
    end else if (!side0.hi) begin
      dvd0 = idx0;
      dvs0 = geom.num;
    end else begin
      dvd0 = idx0 - geom.first[ccim_pkg::DW-1:0];
      dvs0 = geom.num - 1'b1;
    end
  end

  logic                    vd;
  logic [ccim_pkg::DW-1:0] qd;
  logic [ccim_pkg::DW-1:0] rd;
  ccim_pkg::side_t         sided;

  ccim_pipe_div u_pdiv (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (v0),
    .in_dividend   (dvd0),
    .in_divisor    (dvs0),
    .in_side       (side0),
    .out_valid     (vd),
    .out_quotient  (qd),
    .out_remainder (rd),
    .out_side      (sided)
  );

  // chunk and offset stage
  logic                    v1;
  logic [ccim_pkg::DW-1:0] chunk1;
  logic [ccim_pkg::DW-1:0] mop1;
  logic [ccim_pkg::DW-1:0] off1;
  logic                    oor1;
  logic [ccim_pkg::DW:0]   wrap_sum;
  logic [ccim_pkg::DW-1:0] wrap_chunk;
  logic [ccim_pkg::DW-1:0] rest;

  assign rest       = geom.num - 1'b1;
  assign wrap_sum   = {1'b0, rd} + {1'b0, geom.fm};
  assign wrap_chunk = (wrap_sum >= {1'b0, rest}) ? ccim_pkg::DW'(wrap_sum - {1'b0, rest})
                                                 : wrap_sum[ccim_pkg::DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= vd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oor1 <= sided.oor;
      if (sided.oor) begin
        chunk1 <= '0;
        mop1   <= '0;
        off1   <= '0;
      end else if (!sided.cyc) begin
        chunk1 <= qd;
        mop1   <= '0;
        off1   <= sided.idx;
      end else if (!sided.hi) begin
        chunk1 <= rd;
        mop1   <= rd;
        off1   <= qd;
      end else begin
        chunk1 <= wrap_chunk;
        mop1   <= wrap_chunk;
        off1   <= geom.last + qd;
      end
    end
  end

  // multiply stage
  logic                      v2;
  logic [ccim_pkg::DW-1:0]   chunk2;
  logic [ccim_pkg::DW-1:0]   prod2;
  logic [ccim_pkg::DW-1:0]   off2;
  logic                      oor2;
  logic [2*ccim_pkg::DW-1:0] prod_full;

  assign prod_full = mop1 * geom.len;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chunk2 <= chunk1;
      prod2  <= prod_full[ccim_pkg::DW-1:0];
      off2   <= off1;
      oor2   <= oor1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {geom.num, chunk2, prod2 + off2};
      m_axis_tuser <= oor2;
    end
  end

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:0] == 64'd0)
    else $error("out-of-range result carries a slot or chunk");

  a_total_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[95:64] == geom.num)
    else $error("chunk_total differs from geometry");

  a_chunk_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:32] < geom.num)
    else $error("chunk number beyond chunk count");

  a_geom_sane: assert property (@(posedge clk) disable iff (rst)
    geom.ready |-> geom.len != '0 && geom.num != '0)
    else $error("geometry ready with zero length or count");

endmodule
